// ----- hdl/ssdc_pkg.sv -----
`default_nettype none
package ssdc_pkg;

  // grid and field widths
  localparam int GRID_POINTS = 9;
  localparam int GIDX_W      = 4;
  localparam int CMD_W       = 16;
  localparam int SPD_W       = 16;
  localparam int FRAC_W      = 13;
  localparam int TAB_W       = 9;
  localparam int EFF_W       = 17;
  localparam int CFG_W       = 16;
  localparam int WHEELS      = 4;

  // register indexes
  localparam logic REG_P_GAIN       = 1'b0;
  localparam logic REG_EFFORT_LIMIT = 1'b1;
  localparam logic [CFG_W-1:0] EFFORT_LIMIT_RST = 16'd5000;

  // mixing constants: 2000*lin +- 1500*ang over 270
  localparam logic [10:0] LIN_MIX   = 11'd2000;
  localparam logic [10:0] TRACK_MM  = 11'd1500;
  localparam logic [8:0]  WHEEL_DIA = 9'd270;
  localparam logic [6:0]  TAB_SCALE = 7'd100;

  localparam logic signed [CMD_W-1:0] CMD_ONE = 16'sd16384;

  localparam logic signed [CMD_W-1:0] GRID_Q14 [GRID_POINTS] = '{
    -16'sd16384, -16'sd11469, -16'sd6554, -16'sd3277, 16'sd0,
    16'sd3277, 16'sd6554, 16'sd11469, 16'sd16384
  };

  // linear velocity, hundredths of m/s, [throttle][steering]
  localparam logic signed [TAB_W-1:0] LIN_TAB [GRID_POINTS][GRID_POINTS] = '{
    '{-9'sd80, -9'sd132, -9'sd177, -9'sd182, -9'sd200, -9'sd182, -9'sd177, -9'sd132, -9'sd80},
    '{-9'sd77, -9'sd87, -9'sd97, -9'sd92, -9'sd105, -9'sd92, -9'sd97, -9'sd87, -9'sd77},
    '{-9'sd35, -9'sd27, -9'sd27, -9'sd30, -9'sd30, -9'sd30, -9'sd27, -9'sd27, -9'sd35},
    '{-9'sd10, -9'sd10, -9'sd7, 9'sd0, 9'sd0, 9'sd0, -9'sd7, -9'sd10, -9'sd10},
    '{9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0},
    '{9'sd12, 9'sd10, 9'sd10, 9'sd0, 9'sd0, 9'sd0, 9'sd10, 9'sd10, 9'sd12},
    '{9'sd22, 9'sd30, 9'sd25, 9'sd32, 9'sd35, 9'sd32, 9'sd25, 9'sd30, 9'sd22},
    '{9'sd52, 9'sd85, 9'sd102, 9'sd110, 9'sd110, 9'sd110, 9'sd102, 9'sd85, 9'sd52},
    '{9'sd75, 9'sd125, 9'sd190, 9'sd207, 9'sd210, 9'sd207, 9'sd190, 9'sd125, 9'sd75}
  };

  // angular velocity, hundredths of rad/s, [throttle][steering]
  localparam logic signed [TAB_W-1:0] ANG_TAB [GRID_POINTS][GRID_POINTS] = '{
    '{-9'sd100, -9'sd40, -9'sd17, -9'sd3, 9'sd0, 9'sd3, 9'sd17, 9'sd40, 9'sd100},
    '{-9'sd95, -9'sd40, -9'sd23, -9'sd3, 9'sd0, 9'sd3, 9'sd23, 9'sd40, 9'sd95},
    '{-9'sd122, -9'sd40, -9'sd17, -9'sd2, 9'sd0, 9'sd2, 9'sd17, 9'sd40, 9'sd122},
    '{-9'sd140, -9'sd30, -9'sd2, 9'sd0, 9'sd0, 9'sd0, 9'sd2, 9'sd30, 9'sd140},
    '{-9'sd150, -9'sd30, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd0, 9'sd30, 9'sd150},
    '{-9'sd172, -9'sd32, -9'sd2, 9'sd0, 9'sd0, 9'sd0, 9'sd2, 9'sd32, 9'sd172},
    '{-9'sd150, -9'sd47, -9'sd14, -9'sd2, 9'sd0, 9'sd2, 9'sd14, 9'sd47, 9'sd150},
    '{-9'sd122, -9'sd67, -9'sd22, -9'sd4, 9'sd0, 9'sd4, 9'sd22, 9'sd67, 9'sd122},
    '{-9'sd107, -9'sd72, -9'sd25, -9'sd6, 9'sd0, 9'sd6, 9'sd25, 9'sd72, 9'sd107}
  };

  typedef logic [WHEELS-1:0][SPD_W-1:0] speeds_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [GIDX_W-1:0] ti;
    logic [GIDX_W-1:0] si;
    logic [FRAC_W-1:0] ft;
    logic [FRAC_W-1:0] fs;
    logic [FRAC_W-1:0] dt;
    logic [FRAC_W-1:0] ds;
    speeds_t           spd;
  } item_t;

endpackage
`default_nettype wire

// ----- hdl/ssdc_front.sv -----
`default_nettype none
module ssdc_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  signed [ssdc_pkg::CMD_W-1:0] throttle_i,
  input  wire  signed [ssdc_pkg::CMD_W-1:0] steering_i,
  input  wire  ssdc_pkg::speeds_t          spd_i,
  output logic                             push_o,
  input  wire                              full_i,
  output ssdc_pkg::item_t                  item_o
);
  import ssdc_pkg::*;

  logic            f_valid_q;
  item_t           item_q;
  item_t           item_d;
  logic signed [CMD_W-1:0] t_sat;
  logic signed [CMD_W-1:0] s_sat;
  logic [GIDX_W-1:0] tc;
  logic [GIDX_W-1:0] sc;
  logic signed [CMD_W-1:0] t_off;
  logic signed [CMD_W-1:0] s_off;
  logic signed [CMD_W-1:0] t_span;
  logic signed [CMD_W-1:0] s_span;

  // saturate commands and find the grid cell of each
  always_comb begin
    t_sat = throttle_i;
    if (throttle_i > CMD_ONE) t_sat = CMD_ONE;
    if (throttle_i < -CMD_ONE) t_sat = -CMD_ONE;
    s_sat = steering_i;
    if (steering_i > CMD_ONE) s_sat = CMD_ONE;
    if (steering_i < -CMD_ONE) s_sat = -CMD_ONE;
    tc = '0;
    sc = '0;
    for (int k = 1; k < GRID_POINTS - 1; k++) begin
      if (t_sat >= GRID_Q14[k]) tc = GIDX_W'(k);
      if (s_sat >= GRID_Q14[k]) sc = GIDX_W'(k);
    end
    t_off  = t_sat - GRID_Q14[tc];
    s_off  = s_sat - GRID_Q14[sc];
    t_span = GRID_Q14[tc + GIDX_W'(1)] - GRID_Q14[tc];
    s_span = GRID_Q14[sc + GIDX_W'(1)] - GRID_Q14[sc];
    item_d.ti  = tc;
    item_d.si  = sc;
    item_d.ft  = t_off[FRAC_W-1:0];
    item_d.fs  = s_off[FRAC_W-1:0];
    item_d.dt  = t_span[FRAC_W-1:0];
    item_d.ds  = s_span[FRAC_W-1:0];
    item_d.spd = spd_i;
  end

  // one holding stage in front of the queue
  assign in_ready_o = !f_valid_q || !full_i;
  assign push_o     = f_valid_q && !full_i;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      f_valid_q <= 1'b1;
    end else if (push_o) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ssdc_queue.sv -----
`default_nettype none
module ssdc_queue #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire  [WIDTH-1:0] data_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (do_pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("queue count overflow");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("queue count missed a push");
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("queue count missed a pop");
`endif

endmodule
`default_nettype wire

// ----- hdl/ssdc_div.sv -----
`default_nettype none
module ssdc_div #(
  parameter int DW    = 32,
  parameter int QW    = 18,
  parameter int SW    = 64,
  parameter int LANES = 2
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire                              valid_i,
  input  wire  [LANES-1:0][DW+QW-1:0]      dividend_i,
  input  wire  [LANES-1:0]                 neg_i,
  input  wire  [DW-1:0]                    divisor_i,
  input  wire  [SW-1:0]                    side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][QW-1:0]         quot_o,
  output logic [LANES-1:0]                 neg_o,
  output logic [SW-1:0]                    side_o
);
  localparam int RW = DW + QW;

  logic [QW-1:0]           vld_q;
  logic [LANES-1:0][RW-1:0] rem_q  [QW];
  logic [LANES-1:0][QW-1:0] quo_q  [QW];
  logic [LANES-1:0]         neg_q  [QW];
  logic [DW-1:0]            dvs_q  [QW];
  logic [SW-1:0]            side_q [QW];

  logic [LANES-1:0][RW-1:0] rem_p  [QW];
  logic [LANES-1:0][QW-1:0] quo_p  [QW];
  logic [LANES-1:0]         neg_p  [QW];
  logic [DW-1:0]            dvs_p  [QW];
  logic [SW-1:0]            side_p [QW];
  logic                     vld_p  [QW];

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_p[s]  = dividend_i;
      assign quo_p[s]  = '0;
      assign neg_p[s]  = neg_i;
      assign dvs_p[s]  = divisor_i;
      assign side_p[s] = side_i;
      assign vld_p[s]  = valid_i;
    end else begin : g_next
      assign rem_p[s]  = rem_q[s-1];
      assign quo_p[s]  = quo_q[s-1];
      assign neg_p[s]  = neg_q[s-1];
      assign dvs_p[s]  = dvs_q[s-1];
      assign side_p[s] = side_q[s-1];
      assign vld_p[s]  = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_p[s];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] shd;
      logic          ge;
      assign shd = RW'(dvs_p[s]) << (QW - 1 - s);
      assign ge  = rem_p[s][l] >= shd;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= ge ? rem_p[s][l] - shd : rem_p[s][l];
          quo_q[s][l] <= quo_p[s][l] | (QW'(ge) << (QW - 1 - s));
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[s]  <= neg_p[s];
        dvs_q[s]  <= dvs_p[s];
        side_q[s] <= side_p[s];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign neg_o   = neg_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
`default_nettype wire

// ----- hdl/ssdc_back.sv -----
`default_nettype none
module ssdc_back (
  input  wire                                         clk_i,
  input  wire                                         rst_ni,
  input  wire                                         q_valid_i,
  input  wire  ssdc_pkg::item_t                       q_item_i,
  output logic                                        q_pop_o,
  input  wire  [ssdc_pkg::CFG_W-1:0]                  p_gain_i,
  input  wire  [ssdc_pkg::CFG_W-1:0]                  effort_limit_i,
  output logic                                        out_valid_o,
  input  wire                                         out_ready_i,
  output logic [ssdc_pkg::WHEELS-1:0][ssdc_pkg::EFF_W-1:0] effort_o
);
  import ssdc_pkg::*;

  localparam int W_W    = 2 * FRAC_W;
  localparam int P_W    = TAB_W + W_W + 1;
  localparam int N_W    = P_W + 2;
  localparam int D1_DW  = 32;
  localparam int D1_QW  = 18;
  localparam int M_W    = 29;
  localparam int X2_W   = M_W + 1;
  localparam int Q2_W   = 21;
  localparam int RCP_W  = 30;
  localparam int RCP_SH = 38;
  localparam int OM_W   = Q2_W + 1;
  localparam int ER_W   = SPD_W + 9;
  localparam int PR_W   = ER_W + CFG_W + 1;

  // ceil(2^38 / 270): exact floor division for every dividend below 2^29
  localparam logic [RCP_W-1:0] WHEEL_DIA_RCP = 30'd1018066323;

  logic en;
  logic b0_vld_q, b1_vld_q, b2_vld_q, b3_vld_q;
  logic w0_vld_q, w1_vld_q, w2_vld_q;
  logic e0_vld_q, e1_vld_q, e2_vld_q;
  logic d1_vld;

  // whole back pipeline moves unless the output item is held
  assign en          = !e2_vld_q || out_ready_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = e2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_vld_q <= 1'b0;
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      w0_vld_q <= 1'b0;
      w1_vld_q <= 1'b0;
      w2_vld_q <= 1'b0;
      e0_vld_q <= 1'b0;
      e1_vld_q <= 1'b0;
      e2_vld_q <= 1'b0;
    end else if (en) begin
      b0_vld_q <= q_valid_i;
      b1_vld_q <= b0_vld_q;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
      w0_vld_q <= d1_vld;
      w1_vld_q <= w0_vld_q;
      w2_vld_q <= w1_vld_q;
      e0_vld_q <= w2_vld_q;
      e1_vld_q <= e0_vld_q;
      e2_vld_q <= e1_vld_q;
    end
  end

  // table corners and weights; corner k: bit 0 next row, bit 1 next column
  logic signed [TAB_W-1:0] lc_q [4];
  logic signed [TAB_W-1:0] ac_q [4];
  logic [FRAC_W-1:0] wt_q [2];
  logic [FRAC_W-1:0] ws_q [2];
  logic [FRAC_W-1:0] dt_q, ds_q;
  speeds_t spd0_q;
  logic [GIDX_W-1:0] ti1, si1;

  assign ti1 = q_item_i.ti + GIDX_W'(1);
  assign si1 = q_item_i.si + GIDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lc_q[0] <= LIN_TAB[q_item_i.ti][q_item_i.si];
      lc_q[1] <= LIN_TAB[ti1][q_item_i.si];
      lc_q[2] <= LIN_TAB[q_item_i.ti][si1];
      lc_q[3] <= LIN_TAB[ti1][si1];
      ac_q[0] <= ANG_TAB[q_item_i.ti][q_item_i.si];
      ac_q[1] <= ANG_TAB[ti1][q_item_i.si];
      ac_q[2] <= ANG_TAB[q_item_i.ti][si1];
      ac_q[3] <= ANG_TAB[ti1][si1];
      wt_q[0] <= q_item_i.dt - q_item_i.ft;
      wt_q[1] <= q_item_i.ft;
      ws_q[0] <= q_item_i.ds - q_item_i.fs;
      ws_q[1] <= q_item_i.fs;
      dt_q    <= q_item_i.dt;
      ds_q    <= q_item_i.ds;
      spd0_q  <= q_item_i.spd;
    end
  end

  // area weights and cell area
  logic signed [TAB_W-1:0] lc1_q [4];
  logic signed [TAB_W-1:0] ac1_q [4];
  logic [W_W-1:0] w_q [4];
  logic [W_W-1:0] dd_q;
  speeds_t spd1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        w_q[k]   <= W_W'(wt_q[k % 2]) * W_W'(ws_q[k / 2]);
        lc1_q[k] <= lc_q[k];
        ac1_q[k] <= ac_q[k];
      end
      dd_q   <= W_W'(dt_q) * W_W'(ds_q);
      spd1_q <= spd0_q;
    end
  end

  // corner products and the divisor
  logic signed [P_W-1:0] lp_q [4];
  logic signed [P_W-1:0] ap_q [4];
  logic [D1_DW-1:0] den_q;
  speeds_t spd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        lp_q[k] <= lc1_q[k] * $signed({1'b0, w_q[k]});
        ap_q[k] <= ac1_q[k] * $signed({1'b0, w_q[k]});
      end
      den_q  <= D1_DW'(dd_q) * D1_DW'(TAB_SCALE);
      spd2_q <= spd1_q;
    end
  end

  // sums, sign and rounded dividend for the interpolation divide
  logic signed [N_W-1:0] nl, na;
  logic [N_W-1:0] ml, ma;
  logic [1:0][D1_DW+D1_QW-1:0] dv1_q;
  logic [1:0] ng1_q;
  logic [D1_DW-1:0] den1_q;
  speeds_t spd3_q;

  always_comb begin
    nl = lp_q[0] + lp_q[1] + lp_q[2] + lp_q[3];
    na = ap_q[0] + ap_q[1] + ap_q[2] + ap_q[3];
    ml = nl[N_W-1] ? N_W'(-nl) : N_W'(nl);
    ma = na[N_W-1] ? N_W'(-na) : N_W'(na);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv1_q[0] <= {1'b0, ml[32:0], 16'b0} + {19'b0, den_q[D1_DW-1:1]};
      dv1_q[1] <= {1'b0, ma[32:0], 16'b0} + {19'b0, den_q[D1_DW-1:1]};
      ng1_q    <= {na[N_W-1], nl[N_W-1]};
      den1_q   <= den_q;
      spd3_q   <= spd2_q;
    end
  end

  logic [1:0][D1_QW-1:0] q1;
  logic [1:0] n1;
  logic [$bits(speeds_t)-1:0] s1;

  ssdc_div #(.DW(D1_DW), .QW(D1_QW), .SW($bits(speeds_t)), .LANES(2)) u_div_vel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (b3_vld_q),
    .dividend_i (dv1_q),
    .neg_i      (ng1_q),
    .divisor_i  (den1_q),
    .side_i     (spd3_q),
    .valid_o    (d1_vld),
    .quot_o     (q1),
    .neg_o      (n1),
    .side_o     (s1)
  );

  // scale linear and angular velocity for mixing
  logic [M_W-1:0] mlin_q, mang_q;
  logic [1:0] n1_q;
  speeds_t spd4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mlin_q <= M_W'(q1[0]) * M_W'(LIN_MIX);
      mang_q <= M_W'(q1[1]) * M_W'(TRACK_MM);
      n1_q   <= n1;
      spd4_q <= s1;
    end
  end

  // right and left numerators, rounded dividends for the wheel divide
  logic signed [M_W:0] sl, sa;
  logic signed [M_W+1:0] rs, ls;
  logic [M_W+1:0] rm, lm;
  logic [1:0][X2_W-1:0] dv2_q;
  logic [1:0] ng2_q;
  speeds_t spd5_q;

  always_comb begin
    sl = n1_q[0] ? -$signed({1'b0, mlin_q}) : $signed({1'b0, mlin_q});
    sa = n1_q[1] ? -$signed({1'b0, mang_q}) : $signed({1'b0, mang_q});
    rs = sl + sa;
    ls = sl - sa;
    rm = rs[M_W+1] ? (M_W+2)'(-rs) : (M_W+2)'(rs);
    lm = ls[M_W+1] ? (M_W+2)'(-ls) : (M_W+2)'(ls);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv2_q[0] <= {1'b0, rm[M_W-1:0]} + X2_W'(WHEEL_DIA[8:1]);
      dv2_q[1] <= {1'b0, lm[M_W-1:0]} + X2_W'(WHEEL_DIA[8:1]);
      ng2_q    <= {ls[M_W+1], rs[M_W+1]};
      spd5_q   <= spd4_q;
    end
  end

  // divide by the wheel diameter: multiply by the scaled reciprocal
  logic [1:0][X2_W+RCP_W-1:0] wp_q;
  logic [1:0] ng3_q;
  speeds_t spd6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        wp_q[l] <= (X2_W+RCP_W)'(dv2_q[l]) * (X2_W+RCP_W)'(WHEEL_DIA_RCP);
      end
      ng3_q  <= ng2_q;
      spd6_q <= spd5_q;
    end
  end

  logic [1:0][Q2_W-1:0] q2;

  assign q2[0] = wp_q[0][RCP_SH+Q2_W-1:RCP_SH];
  assign q2[1] = wp_q[1][RCP_SH+Q2_W-1:RCP_SH];

  // speed error per wheel: right side uses lane 0, left side lane 1
  logic signed [OM_W-1:0] om [2];
  logic signed [ER_W-1:0] err_q [WHEELS];
  speeds_t spd6;

  assign spd6 = spd6_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      om[l] = ng3_q[l] ? -$signed({1'b0, q2[l]}) : $signed({1'b0, q2[l]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        err_q[w] <= $signed({{(ER_W-OM_W){om[w / 2][OM_W-1]}}, om[w / 2]})
                  - $signed({spd6[w][SPD_W-1], spd6[w], 8'b0});
      end
    end
  end

  // gain times error
  logic signed [PR_W-1:0] pr_q [WHEELS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        pr_q[w] <= $signed({1'b0, p_gain_i}) * err_q[w];
      end
    end
  end

  // round off 24 fraction bits, clamp, restore sign
  logic [PR_W-2:0] pm [WHEELS];
  logic [PR_W-2:0] pr [WHEELS];
  logic [EFF_W-1:0] mag [WHEELS];
  logic [EFF_W-1:0] eff_q [WHEELS];

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      pm[w] = pr_q[w][PR_W-1] ? (PR_W-1)'(-pr_q[w]) : pr_q[w][PR_W-2:0];
      pr[w] = (pm[w] + ((PR_W-1)'(1) << 23)) >> 24;
      mag[w] = pr[w][EFF_W-1:0];
      if (mag[w] > {1'b0, effort_limit_i}) mag[w] = {1'b0, effort_limit_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        eff_q[w] <= pr_q[w][PR_W-1] ? -mag[w] : mag[w];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      effort_o[w] = eff_q[w];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/skid_steer_drive_controller_top.sv -----
`default_nettype none
// channel  | direction | handshake                    | payload
// input    | in        | in_valid_i / in_ready_o      | throttle, steering, four wheel speeds
// result   | out       | out_valid_o / out_ready_i    | four wheel efforts
// config   | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while results are taken; the path from an accepted
// input item to its result runs through the front register, the queue, four table and
// product stages, the 18-stage interpolation divider, three mixing stages
// ending in a reciprocal multiply for the divide by 270, three effort stages.
// reset clears all valid state, p_gain to 0 and effort_limit to 5000.
// a held result stalls the back pipeline; the queue lets input keep flowing
// until it fills.
module skid_steer_drive_controller_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  signed [ssdc_pkg::CMD_W-1:0]      throttle_i,
  input  wire  signed [ssdc_pkg::CMD_W-1:0]      steering_i,
  input  wire  signed [ssdc_pkg::SPD_W-1:0]      front_right_speed_i,
  input  wire  signed [ssdc_pkg::SPD_W-1:0]      back_right_speed_i,
  input  wire  signed [ssdc_pkg::SPD_W-1:0]      front_left_speed_i,
  input  wire  signed [ssdc_pkg::SPD_W-1:0]      back_left_speed_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [ssdc_pkg::EFF_W-1:0]      front_right_effort_o,
  output logic signed [ssdc_pkg::EFF_W-1:0]      back_right_effort_o,
  output logic signed [ssdc_pkg::EFF_W-1:0]      front_left_effort_o,
  output logic signed [ssdc_pkg::EFF_W-1:0]      back_left_effort_o,
  input  wire                                    cfg_we_i,
  input  wire                                    cfg_idx_i,
  input  wire  [ssdc_pkg::CFG_W-1:0]             cfg_data_i
);
  import ssdc_pkg::*;

  logic [CFG_W-1:0] p_gain_q;
  logic [CFG_W-1:0] effort_limit_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q       <= '0;
      effort_limit_q <= EFFORT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_P_GAIN:       p_gain_q       <= cfg_data_i;
        REG_EFFORT_LIMIT: effort_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  speeds_t spd;
  item_t   f_item;
  item_t   q_item;
  logic    push, full, q_valid, pop;
  logic [WHEELS-1:0][EFF_W-1:0] eff;

  assign spd = {back_left_speed_i, front_left_speed_i, back_right_speed_i,
                front_right_speed_i};

  ssdc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .throttle_i (throttle_i),
    .steering_i (steering_i),
    .spd_i      (spd),
    .push_o     (push),
    .full_i     (full),
    .item_o     (f_item)
  );

  ssdc_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(item_t))) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  ssdc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (pop),
    .p_gain_i       (p_gain_q),
    .effort_limit_i (effort_limit_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .effort_o       (eff)
  );

  assign front_right_effort_o = eff[0];
  assign back_right_effort_o  = eff[1];
  assign front_left_effort_o  = eff[2];
  assign back_left_effort_o   = eff[3];

`ifndef SYNTHESIS
  a_right_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (front_right_effort_o <= $signed({1'b0, effort_limit_q})) &&
      (front_right_effort_o >= -$signed({1'b0, effort_limit_q})) &&
      (back_right_effort_o <= $signed({1'b0, effort_limit_q})) &&
      (back_right_effort_o >= -$signed({1'b0, effort_limit_q})))
    else $error("right effort beyond limit");
  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (front_left_effort_o <= $signed({1'b0, effort_limit_q})) &&
      (front_left_effort_o >= -$signed({1'b0, effort_limit_q})) &&
      (back_left_effort_o <= $signed({1'b0, effort_limit_q})) &&
      (back_left_effort_o >= -$signed({1'b0, effort_limit_q})))
    else $error("left effort beyond limit");
  a_zero_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && p_gain_q == '0) |->
      (front_right_effort_o == '0) && (back_right_effort_o == '0) &&
      (front_left_effort_o == '0) && (back_left_effort_o == '0))
    else $error("nonzero effort with zero gain");
`endif

endmodule
`default_nettype wire

// ----- verif/skid_steer_drive_controller_top_test.sv -----
`timescale 1ns / 1ps
module skid_steer_drive_controller_top_test;
  import ssdc_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [EFF_W-1:0] eff [WHEELS];
  } efforts_t;

  // effort predictor and store of expected efforts
  class effort_board;
    logic [CFG_W-1:0] gain;
    logic [CFG_W-1:0] limit;
    efforts_t pending [$];
    int n_bad;
    int n_seen;

    function new();
      gain = '0;
      limit = EFFORT_LIMIT_RST;
      n_bad = 0;
      n_seen = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_P_GAIN) begin
        gain = val;
      end else begin
        limit = val;
      end
    endfunction

    // division rounding ties away from zero
    function longint round_div(longint n, longint d);
      if (n >= 0) begin
        return (n + d / 2) / d;
      end
      return -((-n + d / 2) / d);
    endfunction

    function int grid_cell(int v);
      int c;
      c = 0;
      for (int k = 1; k < GRID_POINTS - 1; k++) begin
        if (v >= GRID_Q14[k]) c = k;
      end
      return c;
    endfunction

    // bilinear table lookup, Q16.16
    function longint table_lookup(bit use_ang, int t, int s);
      int i;
      int j;
      longint dt;
      longint ds;
      longint ft;
      longint fs;
      longint a;
      longint b;
      longint c;
      longint d;
      longint num;
      i = grid_cell(t);
      j = grid_cell(s);
      dt = GRID_Q14[i + 1] - GRID_Q14[i];
      ds = GRID_Q14[j + 1] - GRID_Q14[j];
      ft = t - GRID_Q14[i];
      fs = s - GRID_Q14[j];
      a = use_ang ? ANG_TAB[i][j] : LIN_TAB[i][j];
      b = use_ang ? ANG_TAB[i + 1][j] : LIN_TAB[i + 1][j];
      c = use_ang ? ANG_TAB[i][j + 1] : LIN_TAB[i][j + 1];
      d = use_ang ? ANG_TAB[i + 1][j + 1] : LIN_TAB[i + 1][j + 1];
      num = a * (dt - ft) * (ds - fs) + b * ft * (ds - fs) + c * (dt - ft) * fs + d * ft * fs;
      return round_div(num * 65536, 100 * dt * ds);
    endfunction

    function logic signed [EFF_W-1:0] wheel_effort(longint wref, logic signed [SPD_W-1:0] spd);
      longint err;
      longint e;
      longint lim;
      err = wref - longint'(spd) * 256;
      e = round_div(longint'(gain) * err, longint'(1) << 24);
      lim = longint'(limit);
      if (e > lim) e = lim;
      if (e < -lim) e = -lim;
      return e[EFF_W-1:0];
    endfunction

    function int clamp_cmd(logic signed [CMD_W-1:0] v);
      if (v > CMD_ONE) return CMD_ONE;
      if (v < -CMD_ONE) return -CMD_ONE;
      return v;
    endfunction

    function void note_item(logic signed [CMD_W-1:0] thr, logic signed [CMD_W-1:0] str,
                            logic signed [SPD_W-1:0] spd [WHEELS]);
      int t;
      int s;
      longint lin;
      longint ang;
      longint right;
      longint left;
      efforts_t x;
      t = clamp_cmd(thr);
      s = clamp_cmd(str);
      lin = table_lookup(1'b0, t, s);
      ang = table_lookup(1'b1, t, s);
      right = round_div(2000 * lin + 1500 * ang, 270);
      left = round_div(2000 * lin - 1500 * ang, 270);
      x.eff[0] = wheel_effort(right, spd[0]);
      x.eff[1] = wheel_effort(right, spd[1]);
      x.eff[2] = wheel_effort(left, spd[2]);
      x.eff[3] = wheel_effort(left, spd[3]);
      pending.insert(pending.size(), x);
    endfunction

    task report_mismatch(string what, int wheel, int got, int want);
      n_bad++;
      $display("MISMATCH %s wheel %0d: got %0d want %0d", what, wheel, got, want);
    endtask

    task check_result(efforts_t got);
      efforts_t want;
      n_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result with no item outstanding", 0, 0, 0);
        return;
      end
      want = pending.pop_front();
      for (int w = 0; w < WHEELS; w++) begin
        if (got.eff[w] !== want.eff[w]) begin
          report_mismatch("effort", w, got.eff[w], want.eff[w]);
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CMD_W-1:0] throttle_i = '0;
  logic signed [CMD_W-1:0] steering_i = '0;
  logic signed [SPD_W-1:0] front_right_speed_i = '0;
  logic signed [SPD_W-1:0] back_right_speed_i = '0;
  logic signed [SPD_W-1:0] front_left_speed_i = '0;
  logic signed [SPD_W-1:0] back_left_speed_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [EFF_W-1:0] front_right_effort_o;
  logic signed [EFF_W-1:0] back_right_effort_o;
  logic signed [EFF_W-1:0] front_left_effort_o;
  logic signed [EFF_W-1:0] back_left_effort_o;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  effort_board board = new();
  int n_items = 0;
  int idle_cycles = 0;
  bit sink_hold = 1'b0;

  always #2 clk_i = ~clk_i;

  skid_steer_drive_controller_top i_dut (.*);

  // random gap, mostly short and sometimes long
  function int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  // result side: random stalls and checking
  always @(posedge clk_i) begin
    efforts_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.eff[0] = front_right_effort_o;
      got.eff[1] = back_right_effort_o;
      got.eff[2] = front_left_effort_o;
      got.eff[3] = back_left_effort_o;
      board.check_result(got);
    end
    if (sink_hold) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= (gap_len() == 0);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !in_valid_i &&
        board.pending.size() == 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", board.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, val);
  endtask

  task automatic send_item(logic signed [CMD_W-1:0] thr, logic signed [CMD_W-1:0] str,
                           logic signed [SPD_W-1:0] s0, logic signed [SPD_W-1:0] s1,
                           logic signed [SPD_W-1:0] s2, logic signed [SPD_W-1:0] s3);
    logic signed [SPD_W-1:0] spd [WHEELS];
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    throttle_i <= thr;
    steering_i <= str;
    front_right_speed_i <= s0;
    back_right_speed_i <= s1;
    front_left_speed_i <= s2;
    back_left_speed_i <= s3;
    spd = '{s0, s1, s2, s3};
    do @(posedge clk_i); while (!in_ready_o);
    board.note_item(thr, str, spd);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // command value biased toward grid points and the clamp range
  function logic signed [CMD_W-1:0] rand_cmd();
    int r;
    r = int'($urandom_range(0, 9));
    if (r == 0) return CMD_W'($urandom());
    if (r < 3) begin
      return CMD_W'(int'(GRID_Q14[$urandom_range(0, GRID_POINTS - 1)]) +
                    int'($urandom_range(0, 2)) - 1);
    end
    return CMD_W'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function logic signed [SPD_W-1:0] rand_speed();
    if ($urandom_range(0, 3) == 0) return SPD_W'($urandom());
    return SPD_W'(int'($urandom_range(0, 8000)) - 4000);
  endfunction

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      send_item(rand_cmd(), rand_cmd(), rand_speed(), rand_speed(), rand_speed(), rand_speed());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] gains [6];
    logic [CFG_W-1:0] limits [6];
    gains = '{16'd0, 16'd256, 16'hFFFF, 16'd1200, 16'd37, 16'd5000};
    limits = '{16'd5000, 16'hFFFF, 16'd0, 16'd300, 16'd1, 16'd40000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset gain gives zero efforts
    send_item(16'sd16384, 16'sd0, 16'sd100, -16'sd100, 16'sd0, 16'sd0);
    wait_drained();
    write_reg(REG_P_GAIN, 16'd2048);
    write_reg(REG_EFFORT_LIMIT, 16'hFFFF);
    // grid corners, out-of-range commands and speed extremes
    send_item(-16'sd16384, -16'sd16384, 16'sh7FFF, 16'sh8000, 16'sd0, -16'sd1);
    send_item(16'sd16384, 16'sd16384, 16'sh8000, 16'sh7FFF, 16'sd1, 16'sd0);
    send_item(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(16'sd16385, -16'sd16385, 16'sd256, 16'sd256, -16'sd256, -16'sd256);
    for (int k = 0; k < GRID_POINTS; k++) begin
      send_item(GRID_Q14[k], GRID_Q14[GRID_POINTS - 1 - k], 16'sd0, 16'sd10, -16'sd10, 16'sd0);
      send_item(GRID_Q14[k] - 1, GRID_Q14[k] + 1, 16'sd5, 16'sd0, 16'sd0, -16'sd5);
    end
    send_item(16'sd0, 16'sd0, 16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555);
    // zero limit forces all efforts to zero
    wait_drained();
    write_reg(REG_EFFORT_LIMIT, 16'd0);
    send_item(16'sd16384, 16'sd8000, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0);
    wait_drained();

    // random phases across register settings
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_P_GAIN, gains[p]);
      write_reg(REG_EFFORT_LIMIT, limits[p]);
      if (p == 3) sink_hold = 1'b1;
      random_items(190);
      sink_hold = 1'b0;
      wait_drained();
    end

    $display("sent %0d items, checked %0d results over six gain and limit settings",
             n_items, board.n_seen);
    $display("covered grid lines, command clamping, zero limit and speed extremes");
    if (board.n_bad == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
